/* rtl/core/wdpe_pkg.sv */
// Shared types and constants for the word delta patch encoder.
// Used by wdpe_ctrl, wdpe_datapath and word_delta_patch_encoder; no dependencies.
package wdpe_pkg;

    // Default depth of the run buffer, in 64-bit words
    localparam int DEFAULT_RUN_WORDS = 32;

    // Field widths fixed by the record format
    localparam int WORD_W  = 64;
    localparam int VB_W    = 4;
    localparam int GAP_W   = 32;
    localparam int REC_W   = 9;
    localparam int TOT_W   = 32;
    localparam int KIND_W  = 2;

    // Bytes in a full word
    localparam logic [VB_W-1:0] FULL_BYTES = 4'd8;

    // Record kinds on the result channel
    localparam logic [KIND_W-1:0] KIND_HDR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TERM = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;      // latch the input request
        logic apply;       // fold the latched word into gap or run buffer
        logic hdr;         // load a record header into the result register
        logic pay;         // load the next payload word into the result register
        logic term;        // load the terminator into the result register
        logic flush_done;  // close the record: count bytes, clear gap and run
        logic flush_last;  // this record ends the results of the current request
    } wdpe_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic equal;       // latched word compares equal over its valid bytes
        logic short_word;  // latched word has fewer than eight valid bytes
        logic region_end;  // latched word closes the region
        logic run_empty;   // no words buffered
        logic run_full;    // buffer holds its full depth
        logic last_word;   // next payload word is the last of the record
        logic out_free;    // result register can take a new record this cycle
    } wdpe_status_t;

endpackage

/* rtl/core/wdpe_ctrl.sv */
// Sequencing controller of the word delta patch encoder.
// Depends on wdpe_pkg; drives wdpe_datapath through command/status structs.
module wdpe_ctrl
    import wdpe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         word_valid,
    output logic         word_stall,
    input  wdpe_status_t status,
    output wdpe_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_APPLY  = 3'd2;
    localparam logic [2:0] ST_END    = 3'd3;
    localparam logic [2:0] ST_HDR    = 3'd4;
    localparam logic [2:0] ST_PAY    = 3'd5;
    localparam logic [2:0] ST_TERM   = 3'd6;

    // Which step a record flush returns to
    localparam logic [1:0] PH_PRE  = 2'd0;
    localparam logic [1:0] PH_POST = 2'd1;
    localparam logic [1:0] PH_END  = 2'd2;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;

    // Take a request only between items
    assign word_stall = (state_reg != ST_IDLE);

    // Step through compare, apply, flush and terminator
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cmd.accept     = 1'b0;
        cmd.apply      = 1'b0;
        cmd.hdr        = 1'b0;
        cmd.pay        = 1'b0;
        cmd.term       = 1'b0;
        cmd.flush_done = 1'b0;
        // Decide whether the current flush carries the final result of the request
        case (phase_reg)
            PH_PRE:  cmd.flush_last = (status.equal || !status.short_word)
                                      && !status.region_end;
            PH_POST: cmd.flush_last = !status.region_end;
            default: cmd.flush_last = 1'b0;
        endcase
        unique case (state_reg)
            ST_IDLE:
            begin
                if (word_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if ((status.equal && !status.run_empty) || (!status.equal && status.run_full))
                begin
                    phase_next = PH_PRE;
                    state_next = ST_HDR;
                end
                else
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                cmd.apply = 1'b1;
                if (!status.equal && status.short_word)
                begin
                    phase_next = PH_POST;
                    state_next = ST_HDR;
                end
                else
                begin
                    state_next = ST_END;
                end
            end
            ST_END:
            begin
                if (!status.region_end)
                begin
                    state_next = ST_IDLE;
                end
                else if (!status.run_empty)
                begin
                    phase_next = PH_END;
                    state_next = ST_HDR;
                end
                else
                begin
                    state_next = ST_TERM;
                end
            end
            ST_HDR:
            begin
                if (status.out_free)
                begin
                    cmd.hdr    = 1'b1;
                    state_next = ST_PAY;
                end
            end
            ST_PAY:
            begin
                if (status.out_free)
                begin
                    cmd.pay = 1'b1;
                    if (status.last_word)
                    begin
                        cmd.flush_done = 1'b1;
                        case (phase_reg)
                            PH_PRE:  state_next = ST_APPLY;
                            PH_POST: state_next = ST_END;
                            default: state_next = ST_TERM;
                        endcase
                    end
                end
            end
            ST_TERM:
            begin
                if (status.out_free)
                begin
                    cmd.term   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and flush phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_PRE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

/* rtl/core/wdpe_datapath.sv */
// Datapath of the word delta patch encoder: input latch, run buffer memory,
// gap and byte counters, result register. Depends on wdpe_pkg.
module wdpe_datapath
    import wdpe_pkg::*;
#(
    parameter int RUN_WORDS = DEFAULT_RUN_WORDS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [WORD_W-1:0]  old_word,
    input  logic [WORD_W-1:0]  new_word,
    input  logic [VB_W-1:0]    valid_bytes,
    input  logic [GAP_W-1:0]   start_offset,
    input  logic               region_end,
    input  wdpe_cmd_t          cmd,
    output wdpe_status_t       status,
    output logic               rec_valid,
    input  logic               rec_stall,
    output logic [KIND_W-1:0]  kind,
    output logic [GAP_W-1:0]   gap_bytes,
    output logic [REC_W-1:0]   record_bytes,
    output logic [WORD_W-1:0]  payload,
    output logic [VB_W-1:0]    payload_valid,
    output logic [TOT_W-1:0]   changed_total,
    output logic               final_result
);

    localparam int LW = $clog2(RUN_WORDS + 1);
    localparam int AW = (RUN_WORDS > 1) ? $clog2(RUN_WORDS) : 1;

    // Latched request
    logic              equal_reg;
    logic [WORD_W-1:0] word_reg;
    logic [VB_W-1:0]   vb_reg;
    logic              end_reg;

    // Encoder state
    logic [GAP_W-1:0]  gap_reg;
    logic [TOT_W-1:0]  changed_reg;
    logic [LW-1:0]     len_reg;
    logic [VB_W-1:0]   tail_reg;
    logic              region_start_reg;
    logic [LW-1:0]     idx_reg;

    // Run buffer
    logic [WORD_W-1:0] run_mem [RUN_WORDS];
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;

    // Result register
    logic              rv_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [GAP_W-1:0]  gap_out_reg;
    logic [REC_W-1:0]  rec_out_reg;
    logic [WORD_W-1:0] pay_out_reg;
    logic [VB_W-1:0]   pv_out_reg;
    logic [TOT_W-1:0]  tot_out_reg;
    logic              final_out_reg;

    logic [VB_W-1:0]   vb_clamp;
    logic [WORD_W-1:0] byte_mask;
    logic [LW-1:0]     len_m1;
    logic [REC_W-1:0]  rec_bytes;
    logic [TOT_W:0]    changed_sum;
    logic              out_free;
    logic              last_word;

    // Clamp the byte count and build the compare mask
    always_comb
    begin
        vb_clamp = (valid_bytes > FULL_BYTES) ? FULL_BYTES : valid_bytes;
        for (int b = 0; b < 8; b++)
        begin
            byte_mask[b*8 +: 8] = {8{(VB_W'(b) < vb_clamp)}};
        end
    end

    // Size of the buffered record and the saturating running total
    assign len_m1      = len_reg - LW'(1);
    assign rec_bytes   = REC_W'({len_m1, 3'b000}) + REC_W'(tail_reg);
    assign changed_sum = {1'b0, changed_reg} + (TOT_W + 1)'(rec_bytes);

    assign out_free  = !rv_reg || !rec_stall;
    assign last_word = (idx_reg == len_reg);

    assign status.equal      = equal_reg;
    assign status.short_word = (vb_reg != FULL_BYTES);
    assign status.region_end = end_reg;
    assign status.run_empty  = (len_reg == '0);
    assign status.run_full   = (len_reg == LW'(RUN_WORDS));
    assign status.last_word  = last_word;
    assign status.out_free   = out_free;

    // Read the buffer at word 0 on a header, then one word ahead per payload
    assign rd_en   = cmd.hdr || (cmd.pay && (idx_reg < len_reg));
    assign rd_addr = cmd.hdr ? '0 : idx_reg[AW-1:0];

    // Latch the request
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            equal_reg <= (((old_word ^ new_word) & byte_mask) == '0);
            word_reg  <= new_word & byte_mask;
            vb_reg    <= vb_clamp;
            end_reg   <= region_end;
        end
    end

    // Write changed words into the run buffer
    always_ff @(posedge clk)
    begin
        if (cmd.apply && !equal_reg)
        begin
            run_mem[len_reg[AW-1:0]] <= word_reg;
        end
    end

    // Registered buffer read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= run_mem[rd_addr];
        end
    end

    // Advance gap, totals, run length and payload index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg          <= '0;
            changed_reg      <= '0;
            len_reg          <= '0;
            tail_reg         <= FULL_BYTES;
            region_start_reg <= 1'b1;
            idx_reg          <= '0;
        end
        else
        begin
            if (cmd.accept && region_start_reg)
            begin
                gap_reg          <= start_offset;
                changed_reg      <= '0;
                region_start_reg <= 1'b0;
            end
            if (cmd.apply)
            begin
                if (equal_reg)
                begin
                    gap_reg <= gap_reg + GAP_W'(vb_reg);
                end
                else
                begin
                    len_reg  <= len_reg + LW'(1);
                    tail_reg <= vb_reg;
                end
            end
            if (cmd.hdr)
            begin
                idx_reg <= LW'(1);
            end
            else if (cmd.pay)
            begin
                idx_reg <= idx_reg + LW'(1);
            end
            if (cmd.flush_done)
            begin
                changed_reg <= changed_sum[TOT_W] ? '1 : changed_sum[TOT_W-1:0];
                gap_reg     <= '0;
                len_reg     <= '0;
                tail_reg    <= FULL_BYTES;
            end
            if (cmd.term)
            begin
                region_start_reg <= 1'b1;
            end
        end
    end

    // Hold the result valid until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= 1'b0;
        end
        else if (cmd.hdr || cmd.pay || cmd.term)
        begin
            rv_reg <= 1'b1;
        end
        else if (!rec_stall)
        begin
            rv_reg <= 1'b0;
        end
    end

    // Load the result fields
    always_ff @(posedge clk)
    begin
        if (cmd.hdr)
        begin
            kind_reg      <= KIND_HDR;
            gap_out_reg   <= gap_reg;
            rec_out_reg   <= rec_bytes;
            pay_out_reg   <= '0;
            pv_out_reg    <= '0;
            tot_out_reg   <= '0;
            final_out_reg <= 1'b0;
        end
        else if (cmd.pay)
        begin
            kind_reg      <= KIND_PAY;
            gap_out_reg   <= '0;
            rec_out_reg   <= '0;
            pay_out_reg   <= rd_data_reg;
            pv_out_reg    <= last_word ? tail_reg : FULL_BYTES;
            tot_out_reg   <= '0;
            final_out_reg <= cmd.flush_last && last_word;
        end
        else if (cmd.term)
        begin
            kind_reg      <= KIND_TERM;
            gap_out_reg   <= '0;
            rec_out_reg   <= '0;
            pay_out_reg   <= '0;
            pv_out_reg    <= '0;
            tot_out_reg   <= changed_reg;
            final_out_reg <= 1'b1;
        end
    end

    assign rec_valid     = rv_reg;
    assign kind          = kind_reg;
    assign gap_bytes     = gap_out_reg;
    assign record_bytes  = rec_out_reg;
    assign payload       = pay_out_reg;
    assign payload_valid = pv_out_reg;
    assign changed_total = tot_out_reg;
    assign final_result  = final_out_reg;

`ifndef NO_ASSERTIONS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(RUN_WORDS))
        else $error("run length beyond buffer depth");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.hdr || cmd.pay || cmd.term) |-> out_free)
        else $error("result loaded while previous result still held");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush_done |=> (len_reg == '0) && (gap_reg == '0))
        else $error("run or gap not cleared after record");

    a_term_final: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && (kind == KIND_TERM)) |-> final_result)
        else $error("terminator without final mark");

    a_apply_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply && !equal_reg) |-> (len_reg < LW'(RUN_WORDS)))
        else $error("word stored into full buffer");
`endif

endmodule

/* rtl/core/word_delta_patch_encoder.sv */
// Word delta patch encoder: one request at a time is accepted, then compared and
// folded through the decide, apply and end steps. Each record flushed adds a header
// and its payload words, and a region's last request adds a terminator. The run buffer
// memory's single read port sets the payload rate of one word per cycle while the
// output is not stalled. A result waits in an output register; a stalled result holds
// the sequence. Reset (rst_n, async low) clears counters and starts a new region; the
// run buffer is not cleared, only written entries are ever read.
module word_delta_patch_encoder
    import wdpe_pkg::*;
#(
    parameter int RUN_WORDS = DEFAULT_RUN_WORDS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               word_valid,
    output logic               word_stall,
    input  logic [WORD_W-1:0]  old_word,
    input  logic [WORD_W-1:0]  new_word,
    input  logic [VB_W-1:0]    valid_bytes,
    input  logic [GAP_W-1:0]   start_offset,
    input  logic               region_end,
    output logic               rec_valid,
    input  logic               rec_stall,
    output logic [KIND_W-1:0]  kind,
    output logic [GAP_W-1:0]   gap_bytes,
    output logic [REC_W-1:0]   record_bytes,
    output logic [WORD_W-1:0]  payload,
    output logic [VB_W-1:0]    payload_valid,
    output logic [TOT_W-1:0]   changed_total,
    output logic               final_result
);

    wdpe_cmd_t    cmd;
    wdpe_status_t status;

    // Sequence each request
    wdpe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // Compare, buffer and emit records
    wdpe_datapath #(
        .RUN_WORDS (RUN_WORDS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .old_word      (old_word),
        .new_word      (new_word),
        .valid_bytes   (valid_bytes),
        .start_offset  (start_offset),
        .region_end    (region_end),
        .cmd           (cmd),
        .status        (status),
        .rec_valid     (rec_valid),
        .rec_stall     (rec_stall),
        .kind          (kind),
        .gap_bytes     (gap_bytes),
        .record_bytes  (record_bytes),
        .payload       (payload),
        .payload_valid (payload_valid),
        .changed_total (changed_total),
        .final_result  (final_result)
    );

endmodule

/* verif/word_delta_patch_encoder_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for word_delta_patch_encoder: directed and random word pairs in
// regions, random request idles and record stalls, record stream checked against a scoreboard.
// Depends on wdpe_pkg and the word_delta_patch_encoder RTL.
module word_delta_patch_encoder_tb;
    import wdpe_pkg::*;

    localparam int RUN_DEPTH    = DEFAULT_RUN_WORDS;
    localparam int WORD_TARGET  = 410;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 64;
    localparam int TIMEOUT_NS   = 10_000_000;
    localparam int SHOW_LIMIT   = 10;

    typedef struct packed {
        logic [WORD_W-1:0] old_w;
        logic [WORD_W-1:0] new_w;
        logic [VB_W-1:0]   vb;
        logic [GAP_W-1:0]  offset;
        logic              last;
    } word_req_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [GAP_W-1:0]  gap;
        logic [REC_W-1:0]  bytes;
        logic [WORD_W-1:0] pay;
        logic [VB_W-1:0]   pay_vb;
        logic [TOT_W-1:0]  total;
        logic              fin;
    } patch_rec_t;

    // Clamp the byte count: anything above a full word counts as a full word
    function automatic logic [VB_W-1:0] eff_bytes(input logic [VB_W-1:0] vb);
        return (vb > FULL_BYTES) ? FULL_BYTES : vb;
    endfunction

    function automatic logic [WORD_W-1:0] byte_mask(input logic [VB_W-1:0] vb);
        if (vb >= FULL_BYTES)
        begin
            return '1;
        end
        return (64'd1 << (8 * vb)) - 64'd1;
    endfunction

    // Patch stream predictor and record checker
    class patch_scoreboard;
        patch_rec_t        expected_q[$];
        logic [WORD_W-1:0] run_words[RUN_DEPTH];
        logic [GAP_W-1:0]  gap;
        int                run_len;
        logic [VB_W-1:0]   tail_vb;
        logic [TOT_W-1:0]  changed;
        bit                new_region;
        int                mismatches;
        int                checked;
        int                n_hdr;
        int                n_pay;
        int                n_term;
        int                n_split;

        function new();
            gap        = '0;
            run_len    = 0;
            tail_vb    = FULL_BYTES;
            changed    = '0;
            new_region = 1'b1;
            mismatches = 0;
            checked    = 0;
            n_hdr      = 0;
            n_pay      = 0;
            n_term     = 0;
            n_split    = 0;
        endfunction

        function void add_record(logic [KIND_W-1:0] k, logic [GAP_W-1:0] g,
                                 logic [REC_W-1:0] b, logic [WORD_W-1:0] p,
                                 logic [VB_W-1:0] pv, logic [TOT_W-1:0] t);
            patch_rec_t r;
            r.kind   = k;
            r.gap    = g;
            r.bytes  = b;
            r.pay    = p;
            r.pay_vb = pv;
            r.total  = t;
            r.fin    = 1'b0;
            expected_q.push_back(r);
        endfunction

        // Emit header and payload of the buffered run, then clear gap and run
        function void close_run();
            logic [REC_W-1:0] bytes;
            logic [TOT_W:0]   sum;
            if (run_len == 0)
            begin
                return;
            end
            bytes = REC_W'((run_len - 1) * 8 + int'(tail_vb));
            add_record(KIND_HDR, gap, bytes, '0, '0, '0);
            n_hdr++;
            for (int i = 0; i < run_len; i++)
            begin
                add_record(KIND_PAY, '0, '0, run_words[i],
                           (i == run_len - 1) ? tail_vb : FULL_BYTES, '0);
                n_pay++;
            end
            sum     = {1'b0, changed} + (TOT_W + 1)'(bytes);
            changed = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
            gap     = '0;
            run_len = 0;
            tail_vb = FULL_BYTES;
        endfunction

        // Predict the records caused by one accepted request
        function void note_request(word_req_t r);
            logic [VB_W-1:0]   vb;
            logic [WORD_W-1:0] mask;
            int                first;
            int                tail_idx;
            patch_rec_t        tail_rec;
            first = expected_q.size();
            vb    = eff_bytes(r.vb);
            mask  = byte_mask(vb);
            if (new_region)
            begin
                gap        = r.offset;
                changed    = '0;
                new_region = 1'b0;
            end
            if (((r.old_w ^ r.new_w) & mask) == '0)
            begin
                close_run();
                gap += GAP_W'(vb);
            end
            else
            begin
                // full buffer: flush, new run restarts at relative offset zero
                if (run_len >= RUN_DEPTH)
                begin
                    close_run();
                    n_split++;
                end
                run_words[run_len] = r.new_w & mask;
                run_len++;
                tail_vb = vb;
                if (vb < FULL_BYTES)
                begin
                    close_run();
                end
            end
            if (r.last)
            begin
                close_run();
                add_record(KIND_TERM, '0, '0, '0, '0, changed);
                n_term++;
                new_region = 1'b1;
            end
            // mark the last record of this request
            if (expected_q.size() > first)
            begin
                tail_idx               = expected_q.size() - 1;
                tail_rec               = expected_q[tail_idx];
                tail_rec.fin           = 1'b1;
                expected_q[tail_idx]   = tail_rec;
            end
        endfunction

        function void check_record(patch_rec_t got);
            patch_rec_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                begin
                    $display("%0t: unexpected record kind %0d gap %h bytes %0d pay %h pv %0d",
                             $time, got.kind, got.gap, got.bytes, got.pay, got.pay_vb);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                begin
                    $display("%0t: record mismatch", $time);
                    $display("  expected kind %0d gap %h bytes %0d pay %h pv %0d total %h last %b",
                             want.kind, want.gap, want.bytes, want.pay, want.pay_vb,
                             want.total, want.fin);
                    $display("  actual   kind %0d gap %h bytes %0d pay %h pv %0d total %h last %b",
                             got.kind, got.gap, got.bytes, got.pay, got.pay_vb,
                             got.total, got.fin);
                end
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               word_valid = 1'b0;
    logic               word_stall;
    logic [WORD_W-1:0]  old_word = '0;
    logic [WORD_W-1:0]  new_word = '0;
    logic [VB_W-1:0]    valid_bytes = FULL_BYTES;
    logic [GAP_W-1:0]   start_offset = '0;
    logic               region_end = 1'b0;
    logic               rec_valid;
    logic               rec_stall = 1'b0;
    logic [KIND_W-1:0]  kind;
    logic [GAP_W-1:0]   gap_bytes;
    logic [REC_W-1:0]   record_bytes;
    logic [WORD_W-1:0]  payload;
    logic [VB_W-1:0]    payload_valid;
    logic [TOT_W-1:0]   changed_total;
    logic               final_result;

    patch_scoreboard    sb = new();
    bit                 no_idle = 1'b1;
    bit                 long_hold_req = 1'b0;
    int                 items_sent = 0;

    word_delta_patch_encoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .word_valid    (word_valid),
        .word_stall    (word_stall),
        .old_word      (old_word),
        .new_word      (new_word),
        .valid_bytes   (valid_bytes),
        .start_offset  (start_offset),
        .region_end    (region_end),
        .rec_valid     (rec_valid),
        .rec_stall     (rec_stall),
        .kind          (kind),
        .gap_bytes     (gap_bytes),
        .record_bytes  (record_bytes),
        .payload       (payload),
        .payload_valid (payload_valid),
        .changed_total (changed_total),
        .final_result  (final_result)
    );

    always #5 clk = ~clk;

    function automatic logic [WORD_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int roll;
        if (no_idle)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Receiver stalls; a requested hold-off is counted here
    initial
    begin
        int busy;
        int calm;
        busy = 0;
        calm = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                busy = HOLD_CYCLES;
            end
            if (busy > 0)
            begin
                rec_stall <= 1'b1;
                busy--;
            end
            else if (calm > 0)
            begin
                rec_stall <= 1'b0;
                calm--;
            end
            else
            begin
                busy = pick_gap();
                calm = $urandom_range(0, 12);
                rec_stall <= (busy > 0);
                if (busy > 0)
                begin
                    busy--;
                end
            end
        end
    end

    // Check every accepted record
    always @(posedge clk)
    begin
        if (rst_n && rec_valid && !rec_stall)
        begin
            sb.check_record({kind, gap_bytes, record_bytes, payload, payload_valid,
                             changed_total, final_result});
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    function automatic word_req_t mk(input logic [WORD_W-1:0] o, input logic [WORD_W-1:0] n,
                                     input logic [VB_W-1:0] vb, input logic [GAP_W-1:0] off,
                                     input logic last);
        word_req_t r;
        r.old_w  = o;
        r.new_w  = n;
        r.vb     = vb;
        r.offset = off;
        r.last   = last;
        return r;
    endfunction

    // Offer one request after a random idle stretch and hold it until taken
    task automatic send_word(input word_req_t r);
        int idle;
        idle = pick_gap();
        repeat (idle)
        begin
            @(negedge clk);
            word_valid   <= 1'b0;
            old_word     <= rand64();
            new_word     <= rand64();
            valid_bytes  <= VB_W'($urandom());
            start_offset <= $urandom();
            region_end   <= 1'($urandom());
        end
        @(negedge clk);
        word_valid   <= 1'b1;
        old_word     <= r.old_w;
        new_word     <= r.new_w;
        valid_bytes  <= r.vb;
        start_offset <= r.offset;
        region_end   <= r.last;
        do
        begin
            @(posedge clk);
        end
        while (word_stall);
        sb.note_request(r);
        items_sent++;
    endtask

    // Drop valid and wait until every predicted record has come out
    task automatic pause_until_drained();
        @(negedge clk);
        word_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Mostly full words; short or out-of-range counts mostly on the last word
    function automatic logic [VB_W-1:0] pick_vb(input bit is_last);
        if ($urandom_range(0, 19) == 0)
        begin
            return VB_W'($urandom_range(0, 15));
        end
        if (is_last && $urandom_range(0, 1) == 1)
        begin
            return VB_W'($urandom_range(1, 7));
        end
        return FULL_BYTES;
    endfunction

    function automatic word_req_t make_word(input bit differ, input logic [VB_W-1:0] vb,
                                            input logic [GAP_W-1:0] off, input bit last);
        word_req_t         r;
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] flip;
        int                width;
        mask  = byte_mask(vb);
        width = 8 * int'(eff_bytes(vb));
        r.old_w = rand64();
        case ($urandom_range(0, 15))
            0: r.old_w = '0;
            1: r.old_w = '1;
            default: ;
        endcase
        if (differ && width > 0)
        begin
            flip = rand64() & mask;
            if (flip == '0)
            begin
                flip = 64'd1 << $urandom_range(0, width - 1);
            end
            r.new_w = r.old_w ^ flip;
        end
        else
        begin
            // bytes above the valid count may differ and must be ignored
            r.new_w = r.old_w ^ (rand64() & ~mask);
        end
        r.vb     = vb;
        r.offset = off;
        r.last   = last;
        return r;
    endfunction

    // One region: segments of identical and differing words, last word ends it
    task automatic run_region(input bit long_run);
        int               segs;
        int               len;
        bit               differ;
        bit               first;
        bit               is_last;
        logic [GAP_W-1:0] off;
        logic [VB_W-1:0]  vb;
        case ($urandom_range(0, 3))
            0: off = '0;
            1: off = 32'hFFFF_FF00 + $urandom_range(0, 255);
            default: off = $urandom();
        endcase
        segs  = $urandom_range(1, 5);
        first = 1'b1;
        for (int s = 0; s < segs; s++)
        begin
            differ = 1'($urandom_range(0, 1));
            if (long_run && s == 0)
            begin
                differ = 1'b1;
                len    = $urandom_range(RUN_DEPTH + 1, RUN_DEPTH + 8);
            end
            else if (differ && $urandom_range(0, 14) == 0)
            begin
                len = $urandom_range(RUN_DEPTH - 2, RUN_DEPTH + 8);
            end
            else
            begin
                len = $urandom_range(1, 6);
            end
            for (int k = 0; k < len; k++)
            begin
                is_last = (s == segs - 1) && (k == len - 1);
                vb      = pick_vb(is_last);
                send_word(make_word(differ, vb, first ? off : $urandom(), is_last));
                first = 1'b0;
            end
        end
    endtask

    initial
    begin
        int region_no;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: gap wrap, all-zero and all-one words, ignored and clamped byte counts
        send_word(mk('0, '0, FULL_BYTES, 32'hFFFF_FFF0, 1'b0));
        send_word(mk('1, '1, FULL_BYTES, $urandom(), 1'b0));
        send_word(mk('0, '1, FULL_BYTES, $urandom(), 1'b0));
        send_word(mk('1, '0, FULL_BYTES, $urandom(), 1'b0));
        send_word(mk(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 4'd0, $urandom(), 1'b0));
        send_word(mk({32{2'b10}}, {32{2'b01}}, 4'd15, $urandom(), 1'b0));
        // short words in mid-region: differing flushes, identical adds to gap
        send_word(mk('0, 64'hFFFF_FFFF_FF00_0001, 4'd3, $urandom(), 1'b0));
        send_word(mk('0, 64'hFFFF_FF00_0000_0000, 4'd5, $urandom(), 1'b0));
        send_word(mk(64'h8000_0000_0000_0000, '0, 4'd9, $urandom(), 1'b1));
        // single-word regions
        send_word(mk(64'h0, 64'hFF, 4'd1, 32'h1234_5678, 1'b1));
        send_word(mk(64'h5A5A_0000_FFFF_1234, 64'h5A5A_0000_FFFF_1234, FULL_BYTES, '0, 1'b1));
        // run closed by an identical short word at region end
        send_word(mk('0, 64'h1, FULL_BYTES, 32'h8000_0000, 1'b0));
        send_word(mk(64'h2, '0, FULL_BYTES, $urandom(), 1'b0));
        send_word(mk(64'h00FF_FFFF_FFFF_FFFF, '1, 4'd7, $urandom(), 1'b1));
        // run closed by a differing short word at region end
        send_word(mk(rand64(), ~'0, FULL_BYTES, 32'h7FFF_FFFF, 1'b0));
        send_word(mk(64'h10, 64'h11, 4'd1, $urandom(), 1'b1));
        send_word(mk(64'h5, 64'h5, 4'd12, 32'h0000_0100, 1'b0));
        send_word(mk(64'h1, 64'h2, FULL_BYTES, $urandom(), 1'b1));
        send_word(mk(64'h3, 64'h4, 4'd0, $urandom(), 1'b1));
        pause_until_drained();

        // Random regions; one holds the output long, one waits for a full drain
        no_idle   = 1'b0;
        region_no = 0;
        while (items_sent < WORD_TARGET)
        begin
            if (region_no == 2)
            begin
                long_hold_req = 1'b1;
            end
            if (region_no == 12)
            begin
                pause_until_drained();
            end
            no_idle = (region_no % 6 == 5);
            run_region(region_no == 1);
            region_no++;
        end
        @(negedge clk);
        word_valid <= 1'b0;

        // Drain, then give late extra records time to show up
        while (sb.expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d word pairs over %0d regions: %0d records (%0d split),",
                 items_sent, sb.n_term, sb.n_hdr, sb.n_split);
        $display("%0d payload words; %0d output records checked, %0d mismatches.",
                 sb.n_pay, sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
